/* rtl/lz_two_escape_decompressor_top_assert.svh */
// ----------------------------------------------------------------------------
// LZ two-escape decompressor assertion macros
// Property macros used by the checker file of the decompressor.
// ----------------------------------------------------------------------------
`ifndef LZ_TWO_ESCAPE_DECOMPRESSOR_TOP_ASSERT_SVH
`define LZ_TWO_ESCAPE_DECOMPRESSOR_TOP_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define LZD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define LZD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/lzd_pkg.sv */
// ----------------------------------------------------------------------------
// LZ two-escape decompressor package
// Constants, controller states and the command and status bundles.
// ----------------------------------------------------------------------------
package lzd_pkg;

  localparam int WINDOW_SIZE = 8192;
  localparam int WPTR_W      = $clog2(WINDOW_SIZE);
  localparam int HWM_W       = WPTR_W + 1;
  localparam int DIST_W      = 13;

  localparam logic [7:0] TAG_MASK   = 8'he0;
  localparam logic [7:0] TAG_VALUE  = 8'h80;
  localparam logic [7:0] SHORT_MASK = 8'h0f;

  typedef enum logic [3:0] {
    ST_ESC1,
    ST_ESC2,
    ST_DATA,
    ST_LONG_LO,
    ST_LONG_HI,
    ST_LONG_LEN,
    ST_SHORT,
    ST_STOPPED,
    ST_COPY_RD,
    ST_COPY_WR
  } lzd_state_e;

  typedef struct packed {
    logic wp_clear;
    logic set_esc_long;
    logic set_esc_short;
    logic set_dist_lo;
    logic set_dist_hi;
    logic start_long;
    logic start_short;
    logic lit_push;
    logic copy_read;
    logic copy_push;
    logic stop_emit;
  } lzd_cmd_t;

  typedef struct packed {
    logic esc_long_hit;
    logic esc_short_hit;
    logic tag_ok;
    logic dist_zero;
    logic long_len_zero;
    logic short_len_zero;
    logic rem_last;
    logic need_load;
    logic out_free;
  } lzd_status_t;

endpackage

/* rtl/lzd_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lzd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/lzd_ctrl.sv */
// ----------------------------------------------------------------------------
// LZ two-escape decompressor controller
// Tracks the block phase and sequences match copies byte by byte.
// ----------------------------------------------------------------------------
module lzd_ctrl
  import lzd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_first_i,
  output logic        in_ready_o,
  input  lzd_status_t status_i,
  output lzd_cmd_t    cmd_o
);

  lzd_state_e state_q, state_d, eff_state;
  logic       accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_ESC1;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    accept     = 1'b0;
    eff_state  = state_q;

    unique case (state_q)
      ST_COPY_RD: begin
        cmd_o.copy_read = 1'b1;
        state_d         = ST_COPY_WR;
      end
      ST_COPY_WR: begin
        if (!status_i.need_load || status_i.out_free) begin
          cmd_o.copy_push = 1'b1;
          state_d         = status_i.rem_last ? ST_DATA : ST_COPY_RD;
        end
      end
      default: begin
        // Every input byte may produce one result, so wait for a free output slot.
        in_ready_o = status_i.out_free;
        accept     = in_valid_i && status_i.out_free;
      end
    endcase

    if (accept) begin
      if (in_first_i) begin
        eff_state      = ST_ESC1;
        cmd_o.wp_clear = 1'b1;
      end
      unique case (eff_state)
        ST_ESC1: begin
          cmd_o.set_esc_long = 1'b1;
          state_d            = ST_ESC2;
        end
        ST_ESC2: begin
          cmd_o.set_esc_short = 1'b1;
          state_d             = ST_DATA;
        end
        ST_DATA: begin
          if (status_i.esc_long_hit) begin
            state_d = ST_LONG_LO;
          end else if (status_i.esc_short_hit) begin
            state_d = ST_SHORT;
          end else begin
            cmd_o.lit_push = 1'b1;
          end
        end
        ST_LONG_LO: begin
          cmd_o.set_dist_lo = 1'b1;
          state_d           = ST_LONG_HI;
        end
        ST_LONG_HI: begin
          if (!status_i.tag_ok || status_i.dist_zero) begin
            cmd_o.stop_emit = 1'b1;
            state_d         = ST_STOPPED;
          end else begin
            cmd_o.set_dist_hi = 1'b1;
            state_d           = ST_LONG_LEN;
          end
        end
        ST_LONG_LEN: begin
          if (status_i.long_len_zero) begin
            state_d = ST_DATA;
          end else begin
            cmd_o.start_long = 1'b1;
            state_d          = ST_COPY_RD;
          end
        end
        ST_SHORT: begin
          if (status_i.short_len_zero) begin
            cmd_o.stop_emit = 1'b1;
            state_d         = ST_STOPPED;
          end else begin
            cmd_o.start_short = 1'b1;
            state_d           = ST_COPY_RD;
          end
        end
        default: begin
          state_d = state_q;
        end
      endcase
    end
  end

endmodule

/* rtl/lzd_datapath.sv */
// ----------------------------------------------------------------------------
// LZ two-escape decompressor datapath
// History window, match registers, byte packer and output register.
// ----------------------------------------------------------------------------
module lzd_datapath
  import lzd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [7:0]  in_byte_i,
  input  lzd_cmd_t    cmd_i,
  output lzd_status_t status_o,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  output logic [7:0]  out_byte_o [4],
  output logic [2:0]  out_count_o,
  output logic        out_last_o,
  output logic        out_status_o
);

  logic [7:0]        esc_long_q, esc_short_q;
  logic [DIST_W-1:0] pend_q, pend_d;
  logic [WPTR_W-1:0] copy_dist_q, copy_dist_d;
  logic [7:0]        rem_q, rem_d;
  logic [WPTR_W-1:0] wp_q, wp_d;
  logic [HWM_W-1:0]  hwm_q, hwm_d;
  logic              rd_valid_q, rd_valid_d;
  logic [7:0]        acc_q [3];
  logic [7:0]        acc_d [3];
  logic [1:0]        acc_cnt_q, acc_cnt_d;

  logic              out_valid_q, out_valid_d;
  logic [7:0]        out_byte_q [4];
  logic [7:0]        out_byte_d [4];
  logic [2:0]        out_cnt_q, out_cnt_d;
  logic              out_last_q, out_last_d;
  logic              out_stat_q, out_stat_d;

  logic              push, push_last, load;
  logic [7:0]        push_byte;
  logic [7:0]        rdata;
  logic [WPTR_W-1:0] src_addr;
  logic [HWM_W-1:0]  wp_next_ext;

  assign src_addr    = wp_q - copy_dist_q;
  assign wp_next_ext = {1'b0, wp_q} + HWM_W'(1);
  assign push        = cmd_i.lit_push || cmd_i.copy_push;
  assign push_last   = cmd_i.lit_push || (rem_q == 8'd1);
  // Entries never written since reset read as zero.
  assign push_byte   = cmd_i.lit_push ? in_byte_i : (rd_valid_q ? rdata : 8'h00);
  assign load        = push && (push_last || (acc_cnt_q == 2'd3));

  lzd_ram #(
    .WIDTH (8),
    .DEPTH (WINDOW_SIZE)
  ) u_window (
    .clk_i   (clk_i),
    .we_i    (push),
    .waddr_i (wp_q),
    .wdata_i (push_byte),
    .re_i    (cmd_i.copy_read),
    .raddr_i (src_addr),
    .rdata_o (rdata)
  );

  always_comb begin
    status_o.esc_long_hit   = (in_byte_i == esc_long_q);
    status_o.esc_short_hit  = (in_byte_i == esc_short_q);
    status_o.tag_ok         = ((in_byte_i & TAG_MASK) == TAG_VALUE);
    status_o.dist_zero      = ({in_byte_i[4:0], pend_q[7:0]} == '0);
    status_o.long_len_zero  = (in_byte_i == 8'h00);
    status_o.short_len_zero = ((in_byte_i & SHORT_MASK) == 8'h00);
    status_o.rem_last       = (rem_q == 8'd1);
    status_o.need_load      = (rem_q == 8'd1) || (acc_cnt_q == 2'd3);
    status_o.out_free       = !out_valid_q || out_ready_i;
  end

  always_comb begin
    pend_d      = pend_q;
    copy_dist_d = copy_dist_q;
    rem_d       = rem_q;
    wp_d        = wp_q;
    hwm_d       = hwm_q;
    rd_valid_d  = rd_valid_q;
    acc_d       = acc_q;
    acc_cnt_d   = acc_cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_byte_d  = out_byte_q;
    out_cnt_d   = out_cnt_q;
    out_last_d  = out_last_q;
    out_stat_d  = out_stat_q;

    if (cmd_i.set_dist_lo) begin
      pend_d = {5'd0, in_byte_i};
    end
    if (cmd_i.set_dist_hi) begin
      pend_d = {in_byte_i[4:0], pend_q[7:0]};
    end
    if (cmd_i.start_long) begin
      copy_dist_d = WPTR_W'(pend_q);
      rem_d       = in_byte_i;
    end
    if (cmd_i.start_short) begin
      copy_dist_d = WPTR_W'({1'b0, in_byte_i[7:4]} + 5'd1);
      rem_d       = {4'd0, in_byte_i[3:0]};
    end
    if (cmd_i.copy_read) begin
      rd_valid_d = ({1'b0, src_addr} < hwm_q);
    end
    if (cmd_i.wp_clear) begin
      wp_d = '0;
    end

    if (push) begin
      wp_d = wp_q + WPTR_W'(1);
      if (wp_next_ext > hwm_q) begin
        hwm_d = wp_next_ext;
      end
      if (cmd_i.copy_push) begin
        rem_d = rem_q - 8'd1;
      end
      if (load) begin
        for (int i = 0; i < 4; i++) begin
          if (i < 3 && 2'(i) < acc_cnt_q) begin
            out_byte_d[i] = acc_q[i];
          end else if (3'(i) == {1'b0, acc_cnt_q}) begin
            out_byte_d[i] = push_byte;
          end else begin
            out_byte_d[i] = 8'h00;
          end
        end
        out_cnt_d   = {1'b0, acc_cnt_q} + 3'd1;
        out_last_d  = push_last;
        out_stat_d  = 1'b0;
        out_valid_d = 1'b1;
        acc_cnt_d   = 2'd0;
        for (int i = 0; i < 3; i++) begin
          acc_d[i] = 8'h00;
        end
      end else begin
        acc_d[acc_cnt_q] = push_byte;
        acc_cnt_d        = acc_cnt_q + 2'd1;
      end
    end

    if (cmd_i.stop_emit) begin
      for (int i = 0; i < 4; i++) begin
        out_byte_d[i] = 8'h00;
      end
      out_cnt_d   = 3'd0;
      out_last_d  = 1'b1;
      out_stat_d  = 1'b1;
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_long_q  <= '0;
      esc_short_q <= '0;
      pend_q      <= '0;
      copy_dist_q <= '0;
      rem_q       <= '0;
      wp_q        <= '0;
      hwm_q       <= '0;
      rd_valid_q  <= 1'b0;
      acc_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        acc_q[i] <= '0;
      end
    end else begin
      if (cmd_i.set_esc_long) begin
        esc_long_q <= in_byte_i;
      end
      if (cmd_i.set_esc_short) begin
        esc_short_q <= in_byte_i;
      end
      pend_q      <= pend_d;
      copy_dist_q <= copy_dist_d;
      rem_q       <= rem_d;
      wp_q        <= wp_d;
      hwm_q       <= hwm_d;
      rd_valid_q  <= rd_valid_d;
      acc_q       <= acc_d;
      acc_cnt_q   <= acc_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    out_cnt_q  <= out_cnt_d;
    out_last_q <= out_last_d;
    out_stat_q <= out_stat_d;
  end

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = out_byte_q;
  assign out_count_o  = out_cnt_q;
  assign out_last_o   = out_last_q;
  assign out_status_o = out_stat_q;

endmodule

/* rtl/lz_two_escape_decompressor_top.sv */
// ----------------------------------------------------------------------------
// LZ two-escape decompressor, top level
// Expands a two-escape LZ byte stream into packed groups of up to four bytes.
// ----------------------------------------------------------------------------
//
// Channel   Direction  tdata                              tuser           tlast
// s_axis    in         [7:0] in_byte                      first_of_block  -
// m_axis    out        [31:0] byte_0..3, [34:32] count    status          last_of_run
//
// Literals stream at one per cycle while the output side keeps up. A match
// copies one byte at a time: the history window RAM has a registered read,
// so each byte goes through a read state and then a write-back and packing
// state. Escape and operand bytes are taken at the literal rate. After reset
// the window reads as zeros at once: a high-water mark tracks the written
// region, so there is no clearing pass. A stalled output register holds off
// every input byte, even one that yields no data, while a match copy waits
// on it only when a new result has to be loaded into it.
//
// The first two bytes of a block set the long and the short escape. A long
// escape is followed by a distance low byte, a tag byte (top bits 100, low
// five bits are distance bits 12..8) and a length byte; a short escape by a
// single byte holding distance minus one and a length. A bad tag, a zero
// distance or a zero short length produces one stop transaction (count 0,
// status 1) and the block ignores bytes until the next first_of_block.
module lz_two_escape_decompressor_top
  import lzd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Compressed input stream.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] in_byte
  input  logic        s_axis_tuser_i,   // [0] first_of_block
  // Decompressed output stream.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // [7:0] byte_0, [15:8] byte_1, [23:16] byte_2,
                                        // [31:24] byte_3, [34:32] byte_count, zero pad
  output logic        m_axis_tuser_o,   // [0] status
  output logic        m_axis_tlast_o    // last_of_run
);

  lzd_cmd_t    cmd;
  lzd_status_t status;
  logic [7:0]  out_byte [4];
  logic [2:0]  out_count;

  // Phase tracking and copy sequencing.
  lzd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_first_i (s_axis_tuser_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Window, match registers and the output transaction register.
  lzd_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_byte_i    (s_axis_tdata_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_ready_i  (m_axis_tready_i),
    .out_valid_o  (m_axis_tvalid_o),
    .out_byte_o   (out_byte),
    .out_count_o  (out_count),
    .out_last_o   (m_axis_tlast_o),
    .out_status_o (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = {5'd0, out_count, out_byte[3], out_byte[2], out_byte[1], out_byte[0]};

endmodule

/* rtl/lzd_checker.sv */
// ----------------------------------------------------------------------------
// LZ two-escape decompressor port checker
// Watches the output stream of the top level for consistent transactions.
// ----------------------------------------------------------------------------
`include "lz_two_escape_decompressor_top_assert.svh"

module lzd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [39:0] m_axis_tdata_o,
  input logic        m_axis_tuser_o,
  input logic        m_axis_tlast_o
);

  // A stalled output transaction keeps its contents.
  `LZD_ASSERT_NEXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o) && $stable(m_axis_tuser_o), "output transaction changed while stalled")

  // A stop transaction carries no bytes and closes the run.
  `LZD_ASSERT_NOW(a_stop_form, m_axis_tvalid_o && m_axis_tuser_o, m_axis_tdata_o == 40'd0 && m_axis_tlast_o, "malformed stop transaction")

  // Data transactions carry one to four bytes.
  `LZD_ASSERT_NOW(a_data_count, m_axis_tvalid_o && !m_axis_tuser_o, m_axis_tdata_o[34:32] != 3'd0 && m_axis_tdata_o[34:32] <= 3'd4, "bad byte count")

  // With fewer than four bytes, byte lane 3 and the pad bits are zero.
  `LZD_ASSERT_NOW(a_unused_zero, m_axis_tvalid_o && m_axis_tdata_o[34:32] != 3'd4, m_axis_tdata_o[31:24] == 8'd0 && m_axis_tdata_o[39:35] == 5'd0, "unused byte lanes not zero")

endmodule

bind lz_two_escape_decompressor_top lzd_checker u_lzd_checker (.*);

/* bench/lz_two_escape_decompressor_top_tb.sv */
// ----------------------------------------------------------------------------
// LZ two-escape decompressor testbench
// Drives compressed blocks into the decompressor and checks every packed
// output transaction against a cycle-free model of the decoder kept here.
// ----------------------------------------------------------------------------
module lz_two_escape_decompressor_top_tb
  import lzd_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // One compressed byte as it travels on the input stream.
  typedef struct packed {
    logic [7:0] data;
    logic       first;
  } comp_byte_t;

  // One packed group of decompressed bytes as it leaves the output stream.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      count;
    logic            last;
    logic            status;
  } lzd_group_t;

  logic        clk_i = 1'b1;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = 8'h00;   // [7:0] in_byte
  logic        s_axis_tuser_i = 1'b0;    // [0] first_of_block
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [39:0] m_axis_tdata_o;           // [31:0] byte_0..3, [34:32] byte_count, zero pad
  logic        m_axis_tuser_o;           // [0] status
  logic        m_axis_tlast_o;           // last_of_run

  // Stimulus waiting for the driver, and groups the decoder still owes us.
  comp_byte_t  compressed_bytes[$];
  lzd_group_t  expected_groups[$];

  // Decoder state mirrored by the testbench.
  logic [7:0]        window_copy [WINDOW_SIZE];
  logic [WPTR_W-1:0] wr_ptr;
  lzd_state_e        dec_phase;
  logic [7:0]        esc_long;
  logic [7:0]        esc_short;
  logic [DIST_W-1:0] match_dist;

  int unsigned src_idle_pct = 0;
  int unsigned snk_stall_pct = 0;
  int          mismatch_count = 0;
  int          live_items = 0;
  logic        in_taken;
  comp_byte_t  drv_item;

  lz_two_escape_decompressor_top u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // 10 ns clock.
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Decoder model
  // ---------------------------------------------------------------------------

  // Every decompressed byte goes into the window and onto the output list.
  function automatic void put_hist(input logic [7:0] v, ref logic [7:0] produced[$]);
    window_copy[wr_ptr] = v;
    wr_ptr = wr_ptr + 1'b1;
    produced.push_back(v);
  endfunction

  // A match replays the window byte by byte, so an overlapping copy repeats
  // a short pattern. The pointer difference wraps round the window, which is
  // also how a reach past the start of the block sees older contents.
  function automatic void replay(input logic [DIST_W-1:0] offset, input int len,
                                 ref logic [7:0] produced[$]);
    logic [WPTR_W-1:0] src;
    for (int i = 0; i < len; i++) begin
      src = wr_ptr - offset;
      put_hist(window_copy[src], produced);
    end
  endfunction

  // Works out the groups that one accepted compressed byte causes.
  task automatic expand_byte(input logic [7:0] b, input logic first);
    logic [7:0] produced[$];
    logic       halted;
    lzd_group_t grp;
    halted = 1'b0;
    // A block mark drops whatever was in progress and restarts the window.
    if (first) begin
      wr_ptr = '0;
      dec_phase = ST_ESC1;
    end
    case (dec_phase)
      ST_ESC1: begin
        esc_long = b;
        dec_phase = ST_ESC2;
      end
      ST_ESC2: begin
        esc_short = b;
        dec_phase = ST_DATA;
      end
      ST_DATA: begin
        // The long escape is tested first, so equal escapes mean a long match.
        if (b == esc_long) begin
          dec_phase = ST_LONG_LO;
        end else if (b == esc_short) begin
          dec_phase = ST_SHORT;
        end else begin
          put_hist(b, produced);
        end
      end
      ST_LONG_LO: begin
        match_dist = DIST_W'(b);
        dec_phase = ST_LONG_HI;
      end
      ST_LONG_HI: begin
        if ((b & TAG_MASK) != TAG_VALUE) begin
          halted = 1'b1;
        end else begin
          match_dist = {b[4:0], match_dist[7:0]};
          if (match_dist == '0) begin
            halted = 1'b1;
          end else begin
            dec_phase = ST_LONG_LEN;
          end
        end
      end
      ST_LONG_LEN: begin
        dec_phase = ST_DATA;
        replay(match_dist, int'(b), produced);
      end
      ST_SHORT: begin
        if ((b & SHORT_MASK) == '0) begin
          halted = 1'b1;
        end else begin
          dec_phase = ST_DATA;
          replay(DIST_W'(b[7:4]) + 1'b1, int'(b[3:0]), produced);
        end
      end
      default: begin
        // A stopped block swallows everything until the next block mark.
      end
    endcase

    if (halted) begin
      dec_phase = ST_STOPPED;
      grp = '0;
      grp.last = 1'b1;
      grp.status = 1'b1;
      expected_groups.push_back(grp);
    end else begin
      // Pack up to four bytes per group; the final group of this byte is last.
      for (int i = 0; i < produced.size(); i += 4) begin
        grp = '0;
        for (int k = 0; k < 4 && i + k < produced.size(); k++) begin
          grp.bytes[k] = produced[i + k];
        end
        grp.count = (produced.size() - i >= 4) ? 3'd4 : 3'(produced.size() - i);
        grp.last = (i + 4 >= produced.size());
        expected_groups.push_back(grp);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: a new byte is offered at the falling edge once the previous one
  // has gone, unless the sender decides to idle this cycle. While idle the
  // data lines carry junk that the block must ignore.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid_i || in_taken) begin
        if (compressed_bytes.size() != 0 && $urandom_range(99, 0) >= src_idle_pct) begin
          drv_item = compressed_bytes.pop_front();
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i <= drv_item.data;
          s_axis_tuser_i <= drv_item.first;
        end else begin
          s_axis_tvalid_i <= 1'b0;
          s_axis_tdata_i <= 8'($urandom);
          s_axis_tuser_i <= 1'($urandom);
        end
      end
      m_axis_tready_i <= ($urandom_range(99, 0) >= snk_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: both streams are sampled at the rising edge. An input
  // transaction is run through the model before the output side is looked
  // at, so expectations always exist ahead of the groups they describe.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_taken <= 1'b0;
    end else begin
      lzd_group_t want;
      in_taken <= s_axis_tvalid_i && s_axis_tready_o;
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        expand_byte(s_axis_tdata_i, s_axis_tuser_i);
      end
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (expected_groups.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("%0t: unexpected output transaction tdata=%h status=%b last=%b",
                     $realtime, m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o);
          end
        end else begin
          want = expected_groups.pop_front();
          if (m_axis_tdata_o[7:0] !== want.bytes[0] ||
              m_axis_tdata_o[15:8] !== want.bytes[1] ||
              m_axis_tdata_o[23:16] !== want.bytes[2] ||
              m_axis_tdata_o[31:24] !== want.bytes[3] ||
              m_axis_tdata_o[34:32] !== want.count ||
              m_axis_tdata_o[39:35] !== 5'd0 ||
              m_axis_tuser_o !== want.status ||
              m_axis_tlast_o !== want.last) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("%0t: mismatch, expected bytes=%h count=%0d status=%b last=%b",
                       $realtime, want.bytes, want.count, want.status, want.last);
              $display("%0t:           actual bytes=%h count=%0d status=%b last=%b pad=%h",
                       $realtime, m_axis_tdata_o[31:0], m_axis_tdata_o[34:32],
                       m_axis_tuser_o, m_axis_tlast_o, m_axis_tdata_o[39:35]);
            end
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------------

  // A byte the decoder acts on; these count toward the size of the run.
  task automatic queue_byte(input logic [7:0] data, input logic first);
    compressed_bytes.push_back('{data: data, first: first});
    live_items++;
  endtask

  // A few bytes after a stop, which the block has to drop on the floor.
  task automatic queue_ignored();
    repeat ($urandom_range(3, 1)) compressed_bytes.push_back('{data: 8'($urandom), first: 1'b0});
  endtask

  // One random block. Most of it is well-formed literals and matches with
  // random contents; now and then a match is cut short by the next block
  // mark, a stray byte lands out of step, or a broken operand stops the block.
  task automatic add_block(input int budget);
    logic [7:0]        el;
    logic [7:0]        es;
    logic [7:0]        x;
    logic [7:0]        tag;
    logic [2:0]        bad_top;
    logic [DIST_W-1:0] d;
    int                n;
    int                pick;
    int                fault;
    el = 8'($urandom);
    es = ($urandom_range(15, 0) == 0) ? el : 8'($urandom);
    queue_byte(el, 1'b1);
    queue_byte(es, 1'b0);
    n = 2;
    while (n < budget) begin
      pick = $urandom_range(99, 0);
      if (pick < 50) begin
        do x = 8'($urandom); while (x == el || x == es);
        queue_byte(x, 1'b0);
        n++;
      end else if (pick < 70 && es != el) begin
        x = 8'($urandom);
        if (x[3:0] == 4'd0 && $urandom_range(7, 0) != 0) x[3:0] = 4'($urandom_range(15, 1));
        queue_byte(es, 1'b0);
        queue_byte(x, 1'b0);
        n += 2;
        if (x[3:0] == 4'd0) begin
          queue_ignored();
          return;
        end
      end else if (pick < 94) begin
        d = ($urandom_range(3, 0) == 0) ? DIST_W'($urandom_range(8191, 1))
                                        : DIST_W'($urandom_range(64, 1));
        fault = $urandom_range(29, 0);
        if (fault == 1) d = '0;
        tag = {3'b100, d[12:8]};
        if (fault == 0) begin
          do bad_top = 3'($urandom); while (bad_top == 3'b100);
          tag[7:5] = bad_top;
        end
        queue_byte(el, 1'b0);
        queue_byte(d[7:0], 1'b0);
        queue_byte(tag, 1'b0);
        n += 3;
        if (fault <= 1) begin
          queue_ignored();
          return;
        end
        // Long copies are slow, so only a few use the full length range.
        x = ($urandom_range(9, 0) == 0) ? 8'($urandom) : 8'($urandom_range(12, 0));
        queue_byte(x, 1'b0);
        n++;
      end else if (pick < 97) begin
        // Leave a long match half written; the next block mark cuts it off.
        queue_byte(el, 1'b0);
        if ($urandom_range(1, 0) != 0) queue_byte(8'($urandom), 1'b0);
        return;
      end else begin
        queue_byte(8'($urandom), 1'b0);
        n++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    for (int i = 0; i < WINDOW_SIZE; i++) window_copy[i] = 8'h00;
    wr_ptr = '0;
    dec_phase = ST_ESC1;
    esc_long = 8'h00;
    esc_short = 8'h00;
    match_dist = '0;

    // The block sees reset once, released between edges.
    repeat (4) @(posedge clk_i);
    #2 rst_ni = 1'b1;

    // Directed part. After reset the very first byte is an escape even
    // without a block mark.
    queue_byte(8'hFE, 1'b0);
    queue_byte(8'h01, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b0);
    // Short match reaching well before the block start: distance 16, length 3.
    queue_byte(8'h01, 1'b0);
    queue_byte(8'hF3, 1'b0);
    // Long match, distance 2 and the longest length: a repeating pattern.
    queue_byte(8'hFE, 1'b0);
    queue_byte(8'h02, 1'b0);
    queue_byte(8'h80, 1'b0);
    queue_byte(8'hFF, 1'b0);
    // Longest distance with a zero length, which yields nothing.
    queue_byte(8'hFE, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h9F, 1'b0);
    queue_byte(8'h00, 1'b0);
    // Zero distance stops the block; the next byte is ignored.
    queue_byte(8'hFE, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h80, 1'b0);
    compressed_bytes.push_back('{data: 8'h33, first: 1'b0});
    // Equal escapes, so the escape byte opens a long match, then a bad tag.
    queue_byte(8'h77, 1'b1);
    queue_byte(8'h77, 1'b0);
    queue_byte(8'h77, 1'b0);
    queue_byte(8'h01, 1'b0);
    queue_byte(8'hA0, 1'b0);
    // A new block cuts a long match off halfway.
    queue_byte(8'h10, 1'b1);
    queue_byte(8'h20, 1'b0);
    queue_byte(8'h10, 1'b0);
    queue_byte(8'h05, 1'b0);
    // Fresh block, a short match of length one, then a zero short length.
    queue_byte(8'hC0, 1'b1);
    queue_byte(8'hC1, 1'b0);
    queue_byte(8'hC1, 1'b0);
    queue_byte(8'h01, 1'b0);
    queue_byte(8'hC1, 1'b0);
    queue_byte(8'h00, 1'b0);
    while (compressed_bytes.size() != 0 || s_axis_tvalid_i) @(posedge clk_i);

    // Random part in four handshake phases: free flowing, a lazy sender,
    // a lazy receiver, and both lazy at once.
    live_items = 0;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          src_idle_pct = 0;
          snk_stall_pct = 0;
        end
        1: begin
          src_idle_pct = 63;
          snk_stall_pct = 0;
        end
        2: begin
          src_idle_pct = 0;
          snk_stall_pct = 63;
        end
        default: begin
          src_idle_pct = 22;
          snk_stall_pct = 22;
        end
      endcase
      while (live_items < (ph + 1) * 120) add_block($urandom_range(40, 4));
      while (compressed_bytes.size() != 0 || s_axis_tvalid_i) @(posedge clk_i);
    end

    // Drain what is still owed, then give stray late transactions a chance
    // to show up before the verdict.
    while (expected_groups.size() != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run of this stimulus.
  initial begin
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
